FILE: src/tlpba_pkg.sv
// Package for the two-level pool block allocator.
// Holds sizes, status codes, the tag hash and the front-to-back request type.
// No dependencies.
package tlpba_pkg;

   localparam int MAX_POOLS  = 16;
   localparam int BLOCKS_MAX = 128;
   localparam int POOL_W     = 4;
   localparam int BLOCK_W    = 7;
   localparam int CNT_W      = 8;
   localparam int APOOL_W    = 5;
   localparam int TAG_W      = 16;
   localparam logic [TAG_W-1:0] TAG_MAGIC = 16'hCAFE;
   localparam logic [TAG_W-1:0] TAG_MULT  = 16'(3333333);
   localparam logic [CNT_W-1:0] CFG_RESET = 8'd100;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_MEM   = 2'd1;
   localparam logic [1:0] ST_BAD_HNDL = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [POOL_W-1:0]  pool;
      logic [BLOCK_W-1:0] block;
      logic               tag_ok;
   } req_type;

   // Only the low 16 bits of each product matter after truncation.
   function automatic logic [TAG_W-1:0] make_tag(input logic [BLOCK_W-1:0] blk,
                                                 input logic [POOL_W-1:0] pl);
      logic [TAG_W-1:0] a;
      logic [TAG_W-1:0] b;
      a = TAG_W'({9'd0, blk} * TAG_MULT);
      b = TAG_W'({12'd0, pl} * TAG_MULT);
      return a ^ b ^ TAG_MAGIC;
   endfunction

endpackage

FILE: src/tlpba_front.sv
// Front end: accepts requests, checks the free tag, pushes into a 2-entry queue.
// Depends on tlpba_pkg.
module tlpba_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [tlpba_pkg::POOL_W-1:0]   req_pool_index,
   input  logic [tlpba_pkg::BLOCK_W-1:0]  req_block_index,
   input  logic [tlpba_pkg::TAG_W-1:0]    req_check_tag,
   output logic                           q_valid,
   output tlpba_pkg::req_type             q_data,
   input  logic                           q_pop
);
   tlpba_pkg::req_type entry_ff [2];
   tlpba_pkg::req_type new_req;
   logic [1:0] count_ff, count_in;
   logic rd_ff, wr_ff, push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   // classify: tag check done here so the back end only sees one bit
   // (an allocate always carries a clear tag_ok)
   always_comb begin
      new_req.kind   = req_kind;
      new_req.pool   = req_pool_index;
      new_req.block  = req_block_index;
      new_req.tag_ok = (req_kind == tlpba_pkg::KIND_FREE) && (req_check_tag ==
                        tlpba_pkg::make_tag(req_block_index, req_pool_index));
   end

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) count_in = count_ff + 2'd1;
      else if (!push && q_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= !wr_ff;
         if (q_pop) rd_ff <= !rd_ff;
      end
      if (push) entry_ff[wr_ff] <= new_req;
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_data  = entry_ff[rd_ff];

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count lost a push");
`endif
endmodule

FILE: src/tlpba_back.sv
// Back end: sequencer that runs allocate/free against the pool bitmaps.
// Bitmap is a memory of one 128-bit row per pool; depends on tlpba_pkg.
module tlpba_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tlpba_pkg::CNT_W-1:0]    csr_value,
   input  logic                           q_valid,
   input  tlpba_pkg::req_type             q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [tlpba_pkg::POOL_W-1:0]   rsp_granted_pool,
   output logic [tlpba_pkg::BLOCK_W-1:0]  rsp_granted_block,
   output logic [tlpba_pkg::TAG_W-1:0]    rsp_granted_tag
);
   localparam int BM = tlpba_pkg::BLOCKS_MAX;
   localparam int MP = tlpba_pkg::MAX_POOLS;
   localparam int PW = tlpba_pkg::POOL_W;
   localparam int BW = tlpba_pkg::BLOCK_W;
   localparam int CW = tlpba_pkg::CNT_W;
   localparam int AW = tlpba_pkg::APOOL_W;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_READ, S_ALLOC, S_SCAN, S_FREE, S_ADV, S_OUT
   } state_type;

   state_type           state_ff;
   logic [BM-1:0]       bitmap_mem [MP];
   logic [BM-1:0]       row_ff;
   logic [BM-1:0]       row_in;
   logic [CW-1:0]       lfb_ff [MP];
   logic [MP-1:0]       full_ff;
   logic [AW-1:0]       active_ff, open_ff;
   logic [PW-1:0]       clr_ff;
   logic                clr_done_ff;
   tlpba_pkg::req_type  cur_ff;
   logic [PW-1:0]       pl_ff;
   logic [BW-1:0]       fb_ff;
   logic [CW-1:0]       size;
   logic [BM-1:0]       mask;
   logic [CW-1:0]       first_free;
   logic [CW-1:0]       next_free;
   logic [BM-1:0]       row_set;
   logic                free_bad;

   // clamp the size register
   always_comb begin
      if (csr_value == '0) size = CW'(1);
      else if (csr_value > CW'(BM)) size = CW'(BM);
      else size = csr_value;
   end

   // free blocks in range [lfb, size)
   always_comb begin
      for (int i = 0; i < BM; i++)
         mask[i] = !row_ff[i] && (CW'(i) >= lfb_ff[pl_ff]) && (CW'(i) < size);
   end

   // priority encoders: first free, and first free above it after setting it
   always_comb begin
      first_free = size;
      for (int i = BM-1; i >= 0; i--)
         if (mask[i]) first_free = CW'(i);
   end

   always_comb begin
      row_set = row_ff;
      row_set[fb_ff] = 1'b1;
      next_free = size;
      for (int i = BM-1; i >= 0; i--)
         if (!row_set[i] && CW'(i) > CW'(fb_ff) && CW'(i) < size)
            next_free = CW'(i);
   end

   assign free_bad = (AW'(cur_ff.pool) >= active_ff) || (CW'(cur_ff.block) >= size)
                     || !cur_ff.tag_ok;

   assign q_pop = (state_ff == S_IDLE) && clr_done_ff && q_valid;
   assign row_in = row_set;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         full_ff     <= '0;
         active_ff   <= '0;
         open_ff     <= '0;
         rsp_valid   <= 1'b0;
         for (int p = 0; p < MP; p++) lfb_ff[p] <= '0;
      end else begin
         case (state_ff)
            // one bitmap row per cycle after reset
            S_CLEAR: begin
               bitmap_mem[clr_ff] <= '0;
               clr_ff <= clr_ff + PW'(1);
               if (clr_ff == PW'(MP-1)) begin
                  clr_done_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  cur_ff <= q_data;
                  rsp_status <= tlpba_pkg::ST_OK;
                  rsp_granted_pool  <= '0;
                  rsp_granted_block <= '0;
                  rsp_granted_tag   <= '0;
                  if (q_data.kind == tlpba_pkg::KIND_FREE) begin
                     pl_ff <= q_data.pool;
                     state_ff <= S_FREE;
                  end else begin
                     state_ff <= S_ALLOC;
                  end
               end
            end
            // pick or activate a pool
            S_ALLOC: begin
               if (open_ff >= active_ff) begin
                  if (active_ff >= AW'(MP)) begin
                     rsp_status <= tlpba_pkg::ST_NO_MEM;
                     state_ff <= S_OUT;
                  end else begin
                     bitmap_mem[active_ff[PW-1:0]] <= '0;
                     lfb_ff[active_ff[PW-1:0]] <= '0;
                     full_ff[active_ff[PW-1:0]] <= 1'b0;
                     open_ff   <= active_ff;
                     active_ff <= active_ff + AW'(1);
                     pl_ff     <= active_ff[PW-1:0];
                     state_ff  <= S_READ;
                  end
               end else begin
                  pl_ff <= open_ff[PW-1:0];
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               row_ff <= bitmap_mem[pl_ff];
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (first_free >= size) begin
                  lfb_ff[pl_ff] <= size;
                  full_ff[pl_ff] <= 1'b1;
                  open_ff <= open_ff + AW'(1);
                  state_ff <= S_ADV;
                  fb_ff <= '1;
               end else begin
                  fb_ff <= first_free[BW-1:0];
                  // the bitmap write happens in S_OUT, after fb_ff holds the granted block
                  state_ff <= S_OUT;
                  rsp_granted_pool  <= pl_ff;
                  rsp_granted_block <= first_free[BW-1:0];
                  rsp_granted_tag   <= tlpba_pkg::make_tag(first_free[BW-1:0], pl_ff);
                  cur_ff.tag_ok <= 1'b1;
               end
            end
            // skip full pools one per cycle
            S_ADV: begin
               if (open_ff < active_ff && full_ff[open_ff[PW-1:0]])
                  open_ff <= open_ff + AW'(1);
               else if (cur_ff.kind == tlpba_pkg::KIND_ALLOC && fb_ff == '1
                        && rsp_status == tlpba_pkg::ST_OK
                        && !cur_ff.tag_ok)
                  state_ff <= S_ALLOC;
               else
                  state_ff <= S_OUT;
            end
            S_FREE: begin
               if (free_bad) begin
                  rsp_status <= tlpba_pkg::ST_BAD_HNDL;
               end else begin
                  row_ff <= bitmap_mem[pl_ff];
                  full_ff[pl_ff] <= 1'b0;
                  if (CW'(cur_ff.block) < lfb_ff[pl_ff]) lfb_ff[pl_ff] <= CW'(cur_ff.block);
                  if (AW'(pl_ff) < open_ff) open_ff <= AW'(pl_ff);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (cur_ff.kind == tlpba_pkg::KIND_ALLOC && cur_ff.tag_ok
                   && rsp_status == tlpba_pkg::ST_OK && !rsp_valid) begin
                  // commit the grant; if the pool fills, the response waits until the open pool moves on
                  bitmap_mem[pl_ff] <= row_in;
                  lfb_ff[pl_ff] <= next_free;
                  cur_ff <= {tlpba_pkg::KIND_FREE, cur_ff.pool, cur_ff.block, 1'b0};
                  if (next_free >= size) begin
                     full_ff[pl_ff] <= 1'b1;
                     open_ff <= open_ff + AW'(1);
                     state_ff <= S_ADV;
                  end else begin
                     rsp_valid <= 1'b1;
                  end
               end else if (cur_ff.kind == tlpba_pkg::KIND_FREE && !rsp_valid
                            && rsp_status == tlpba_pkg::ST_OK && !cur_ff.tag_ok) begin
                  rsp_valid <= 1'b1;
               end else if (!rsp_valid) begin
                  if (rsp_status == tlpba_pkg::ST_OK) begin
                     bitmap_mem[pl_ff] <= row_ff & ~(BM'(1) << cur_ff.block);
                  end
                  rsp_valid <= 1'b1;
               end else if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= AW'(MP)) else $error("too many pools");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid) else $error("pop while response pending");
`endif
endmodule

FILE: src/two_level_pool_block_allocator_unit.sv
// Top level of the two-level pool block allocator.
// Instantiates tlpba_front and tlpba_back; depends on tlpba_pkg.
//
//  channel | ports               | handshake
//  req     | req_kind..check_tag | req_valid / req_stall
//  rsp     | rsp_status..tag     | rsp_valid / rsp_stall
//  csr     | csr_wdata           | csr_write
//
// Back end, pop to next pop: a free runs S_FREE, S_OUT; an out-of-memory
// answer S_ALLOC, S_OUT; an allocate S_ALLOC, S_READ, S_SCAN, S_OUT, and S_ADV
// when it fills its pool, skipping full pools one per cycle. A pool found full
// on the scan sends it back through S_ADV to S_ALLOC; each response stall holds
// S_OUT. After reset a pass clearing one row per cycle runs before any pop.
// The front queue holds two requests while the back end stalls.
module two_level_pool_block_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [tlpba_pkg::CNT_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [tlpba_pkg::POOL_W-1:0]   req_pool_index,
   input  logic [tlpba_pkg::BLOCK_W-1:0]  req_block_index,
   input  logic [tlpba_pkg::TAG_W-1:0]    req_check_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [tlpba_pkg::POOL_W-1:0]   rsp_granted_pool,
   output logic [tlpba_pkg::BLOCK_W-1:0]  rsp_granted_block,
   output logic [tlpba_pkg::TAG_W-1:0]    rsp_granted_tag
);
   logic [tlpba_pkg::CNT_W-1:0] size_ff;
   logic q_valid, q_pop;
   tlpba_pkg::req_type q_data;

   // size register
   always_ff @(posedge clock) begin
      if (reset) size_ff <= tlpba_pkg::CFG_RESET;
      else if (csr_write) size_ff <= csr_wdata;
   end

   tlpba_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_pool_index,
      .req_block_index, .req_check_tag, .q_valid, .q_data, .q_pop
   );

   tlpba_back u_back (
      .clock, .reset, .csr_value(size_ff), .q_valid, .q_data, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_granted_pool,
      .rsp_granted_block, .rsp_granted_tag
   );
endmodule
